### rtl/core/timestamp_sync_frame_builder_top_assert.svh
// assertion macros shared by the timestamp sync frame builder modules
`ifndef TIMESTAMP_SYNC_FRAME_BUILDER_TOP_ASSERT_SVH
`define TIMESTAMP_SYNC_FRAME_BUILDER_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSFB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TSFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/tsfb_pkg.sv
// shared constants, types and the crc-8 byte step of the timestamp sync frame builder
package tsfb_pkg;

  localparam int STAMP_BYTES  = 5;
  localparam int PKT_LEN      = STAMP_BYTES + 3;
  localparam int IDX_W        = $clog2(PKT_LEN);
  localparam int STAMP_IDX_W  = (STAMP_BYTES > 1) ? $clog2(STAMP_BYTES) : 1;
  localparam int COUNT_W      = $clog2(STAMP_BYTES + 1);
  localparam int BYTE_POS_W   = 3;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_SOF_MARKER     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CRC_POLYNOMIAL = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_COMMAND   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_COMMAND   = CFG_IDX_W'(3);

  localparam logic [7:0] SOF_MARKER_RST     = 8'hAA;
  localparam logic [7:0] CRC_POLYNOMIAL_RST = 8'h07;
  localparam logic [7:0] SYNC_COMMAND_RST   = 8'h00;
  localparam logic [7:0] STOP_COMMAND_RST   = 8'h01;

  typedef enum logic [3:0] {
    PH_WAIT_PRESS   = 4'b0001,
    PH_WAIT_RELEASE = 4'b0010,
    PH_RUNNING      = 4'b0100,
    PH_STOPPED      = 4'b1000
  } phase_e;

  typedef struct packed {
    logic accept;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic pkt_start;
    logic last_idx;
    logic out_free;
  } dp_status_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### rtl/core/tsfb_ctrl.sv
// controller: idle / packet send sequencing
`include "timestamp_sync_frame_builder_top_assert.svh"

module tsfb_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  tsfb_pkg::dp_status_t   status_i,
  output tsfb_pkg::ctl_cmd_t     cmd_o
);
  import tsfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o   = (state_q != ST_IDLE);
  assign cmd_o.accept = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.emit   = (state_q == ST_SEND) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept && status_i.pkt_start) begin
          state_d = ST_SEND;
        end
      end
      ST_SEND: begin
        if (cmd_o.emit && status_i.last_idx) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `TSFB_ASSERT_NEXT(start_enters_send_a, cmd_o.accept && status_i.pkt_start,
    state_q == ST_SEND, "packet start did not enter send")
  `TSFB_ASSERT_NEXT(last_emit_returns_idle_a, cmd_o.emit && status_i.last_idx,
    state_q == ST_IDLE, "last packet byte did not return to idle")

endmodule

### rtl/core/tsfb_datapath.sv
// datapath: config registers, frame gathering, run phase, packet bytes, crc and output register
`include "timestamp_sync_frame_builder_top_assert.svh"

module tsfb_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsfb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [7:0]                        cfg_data_i,
  input  logic                              func_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              button_level_i,
  input  tsfb_pkg::ctl_cmd_t                cmd_i,
  output tsfb_pkg::dp_status_t              status_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        packet_byte_o,
  output logic [tsfb_pkg::BYTE_POS_W-1:0]   byte_position_o,
  output logic                              last_byte_o,
  output logic                              stop_level_o
);
  import tsfb_pkg::*;

  logic [7:0] sof_q, poly_q, sync_cmd_q, stop_cmd_q;

  logic [7:0]             assembly_q [STAMP_BYTES];
  logic [7:0]             latest_q   [STAMP_BYTES];
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [STAMP_IDX_W-1:0] wr_idx;
  logic                   frame_done;

  phase_e phase_q, phase_d;
  logic   stop_q, stop_d;

  logic [7:0]       cmd_byte_q;
  logic [7:0]       crc_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] ts_idx_full;
  logic [7:0]       cur_byte;
  logic             is_gather;

  logic out_valid_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_q      <= SOF_MARKER_RST;
      poly_q     <= CRC_POLYNOMIAL_RST;
      sync_cmd_q <= SYNC_COMMAND_RST;
      stop_cmd_q <= STOP_COMMAND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SOF_MARKER:     sof_q      <= cfg_data_i;
        CFG_CRC_POLYNOMIAL: poly_q     <= cfg_data_i;
        CFG_SYNC_COMMAND:   sync_cmd_q <= cfg_data_i;
        CFG_STOP_COMMAND:   stop_cmd_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // frame gathering
  assign is_gather  = cmd_i.accept && !func_i;
  assign wr_idx     = (count_q >= COUNT_W'(STAMP_BYTES)) ? '0 : count_q[STAMP_IDX_W-1:0];
  assign frame_done = (wr_idx == STAMP_IDX_W'(STAMP_BYTES - 1));
  assign count_d    = frame_done ? '0 : COUNT_W'(wr_idx) + COUNT_W'(1);

  always_ff @(posedge clk_i) begin
    if (is_gather) begin
      assembly_q[wr_idx] <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int j = 0; j < STAMP_BYTES; j++) begin
        latest_q[j] <= '0;
      end
    end else if (is_gather) begin
      count_q <= count_d;
      if (frame_done) begin
        for (int j = 0; j < STAMP_BYTES; j++) begin
          latest_q[j] <= (STAMP_IDX_W'(j) == wr_idx) ? rx_byte_i : assembly_q[j];
        end
      end
    end
  end

  // run phase
  assign status_o.pkt_start = func_i && (phase_q == PH_RUNNING);

  always_comb begin
    phase_d = phase_q;
    stop_d  = stop_q;
    unique case (phase_q)
      PH_WAIT_PRESS: begin
        if (button_level_i) begin
          phase_d = PH_WAIT_RELEASE;
        end
      end
      PH_WAIT_RELEASE: begin
        if (!button_level_i) begin
          phase_d = PH_RUNNING;
        end
      end
      PH_RUNNING: begin
        if (func_i && button_level_i) begin
          phase_d = PH_STOPPED;
          stop_d  = 1'b1;
        end
      end
      PH_STOPPED: begin
        if (!button_level_i) begin
          phase_d = PH_WAIT_PRESS;
          stop_d  = 1'b0;
        end
      end
      default: phase_d = PH_WAIT_PRESS;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT_PRESS;
      stop_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      phase_q <= phase_d;
      stop_q  <= stop_d;
    end
  end

  // packet byte sequencer
  assign ts_idx_full = idx_q - IDX_W'(2);

  always_comb begin
    if (idx_q == IDX_W'(0)) begin
      cur_byte = sof_q;
    end else if (idx_q == IDX_W'(1)) begin
      cur_byte = cmd_byte_q;
    end else if (idx_q == IDX_W'(PKT_LEN - 1)) begin
      cur_byte = crc_q;
    end else begin
      cur_byte = latest_q[ts_idx_full[STAMP_IDX_W-1:0]];
    end
  end

  assign status_o.last_idx = (idx_q == IDX_W'(PKT_LEN - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.accept && status_o.pkt_start) begin
      idx_q <= '0;
    end else if (cmd_i.emit) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && status_o.pkt_start) begin
      cmd_byte_q <= button_level_i ? stop_cmd_q : sync_cmd_q;
      crc_q      <= '0;
    end else if (cmd_i.emit) begin
      crc_q      <= crc8_byte(crc_q, cur_byte, poly_q);
    end
  end

  // output register
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      packet_byte_o   <= cur_byte;
      byte_position_o <= BYTE_POS_W'(idx_q);
      last_byte_o     <= status_o.last_idx;
      stop_level_o    <= stop_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `TSFB_ASSERT_NOW(stop_matches_phase_a, 1'b1, stop_q == (phase_q == PH_STOPPED),
    "stop line out of step with run phase")
  `TSFB_ASSERT_NOW(count_in_range_a, 1'b1, count_q < COUNT_W'(STAMP_BYTES),
    "frame byte count out of range")

endmodule

### rtl/core/timestamp_sync_frame_builder_top.sv
// top level of the timestamp sync frame builder
//
// Takes serial bytes and timer ticks, each with the start button level. Serial bytes are
// gathered into 5-byte timestamp frames; a complete frame becomes the latest timestamp.
// After a press and release the block runs, and every tick then produces one 8-byte packet:
// start-of-frame marker, command, the latest timestamp and a CRC-8 over the first seven
// bytes. A tick with the button held sends the stop command and raises stop_level_o, which
// falls with a later packet byte sent after an item reads the button released. A serial
// byte or a tick that makes no packet does not stall the input. A packet tick stalls it; the
// byte sequencer gives one byte a cycle unless the output stalls and steps the CRC per byte.
// The next item is taken the cycle after the last byte enters the output register.
`include "timestamp_sync_frame_builder_top_assert.svh"

module timestamp_sync_frame_builder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic [7:0]                        rx_byte_i,
  input  logic                              button_level_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        packet_byte_o,
  output logic [tsfb_pkg::BYTE_POS_W-1:0]   byte_position_o,
  output logic                              last_byte_o,
  output logic                              stop_level_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tsfb_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [7:0]                        cfg_data_i
);
  import tsfb_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  assign cfg_ready_o = 1'b1;

  tsfb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tsfb_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .func_i          (func_i),
    .rx_byte_i       (rx_byte_i),
    .button_level_i  (button_level_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .packet_byte_o   (packet_byte_o),
    .byte_position_o (byte_position_o),
    .last_byte_o     (last_byte_o),
    .stop_level_o    (stop_level_o)
  );

  `TSFB_ASSERT_NOW(no_accept_while_sending_a, cmd.emit, !cmd.accept,
    "item taken while packet bytes still being sent")
  `TSFB_ASSERT_NEXT(emit_fills_output_a, cmd.emit, out_valid_o,
    "packet byte sent but output register empty")

endmodule
